FILE: hdl/rwdc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rwdc_pkg
// Types and constants shared by the dominant color classifier modules.
// ---------------------------------------------------------------------------
package rwdc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 22;
    localparam int LEN_W       = 7;
    localparam int COEF_W      = 16;
    localparam int FRAC_W      = 12;
    localparam int CODE_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SCALED_W    = SUM_W + COEF_W;
    localparam int PROD_W      = SCALED_W + COEF_W;
    localparam int LEN_MAX     = (2 ** LEN_W) - 1;

    // color codes
    localparam logic [CODE_W-1:0] COLOR_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] COLOR_RED   = 2'd1;
    localparam logic [CODE_W-1:0] COLOR_GREEN = 2'd2;
    localparam logic [CODE_W-1:0] COLOR_BLUE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_GAIN        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_GAIN      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_GAIN       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DOMINANCE_RATIO = 3'd4;

    // reset values
    localparam logic [LEN_W-1:0]  WINDOW_LENGTH_RST   = 7'd16;
    localparam logic [COEF_W-1:0] GAIN_RST            = 16'd4096;
    localparam logic [COEF_W-1:0] DOMINANCE_RATIO_RST = 16'd4915;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red_sample;
        logic [SAMPLE_W-1:0] green_sample;
        logic [SAMPLE_W-1:0] blue_sample;
    } sample_t;

    typedef struct packed {
        logic [CODE_W-1:0] color_code;
        logic [SUM_W-1:0]  red_window_sum;
        logic [SUM_W-1:0]  green_window_sum;
        logic [SUM_W-1:0]  blue_window_sum;
    } result_t;

    typedef struct packed {
        logic [SUM_W-1:0] red_sum;
        logic [SUM_W-1:0] green_sum;
        logic [SUM_W-1:0] blue_sum;
    } window_t;

    typedef struct packed {
        logic [LEN_W-1:0]  window_length;
        logic [COEF_W-1:0] red_gain;
        logic [COEF_W-1:0] green_gain;
        logic [COEF_W-1:0] blue_gain;
        logic [COEF_W-1:0] dominance_ratio;
    } cfg_t;

endpackage
`default_nettype wire

FILE: hdl/rwdc_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rwdc_front
// Accepts samples, keeps the saturating window sums and hands each finished
// window to the queue.
// ---------------------------------------------------------------------------
module rwdc_front #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [rwdc_pkg::LEN_W-1:0] window_length,
    input  logic                     sample_valid,
    output logic                     sample_ready,
    input  rwdc_pkg::sample_t        sample,
    input  logic                     queue_full,
    output logic                     push,
    output rwdc_pkg::window_t        push_data
);
    import rwdc_pkg::*;

    localparam logic [LEN_W-1:0] LEN_CAP =
        (MAX_WINDOW > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(MAX_WINDOW);

    logic [LEN_W-1:0] count_reg;
    logic [SUM_W-1:0] red_acc_reg;
    logic [SUM_W-1:0] green_acc_reg;
    logic [SUM_W-1:0] blue_acc_reg;

    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] count_next;
    logic             window_done;
    logic             accept;
    window_t          sum_next;

    function automatic logic [SUM_W-1:0] sat_add(
        input logic [SUM_W-1:0]    acc,
        input logic [SAMPLE_W-1:0] s
    );
        logic [SUM_W:0] total;
        begin
            total = {1'b0, acc} + (SUM_W+1)'(s);
            return total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
        end
    endfunction

    always_comb
    begin
        priority if (window_length == '0)
            len = LEN_W'(1);
        else if (window_length > LEN_CAP)
            len = LEN_CAP;
        else
            len = window_length;
    end

    // count stays below the cap on len, so the increment never wraps
    assign count_next  = count_reg + LEN_W'(1);
    assign window_done = (count_next >= len);

    assign sum_next.red_sum   = sat_add(red_acc_reg, sample.red_sample);
    assign sum_next.green_sum = sat_add(green_acc_reg, sample.green_sample);
    assign sum_next.blue_sum  = sat_add(blue_acc_reg, sample.blue_sample);

    // only a window-closing sample needs room in the queue
    assign sample_ready = !(window_done && queue_full);
    assign accept       = sample_valid && sample_ready;
    assign push         = accept && window_done;
    assign push_data    = sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            red_acc_reg   <= '0;
            green_acc_reg <= '0;
            blue_acc_reg  <= '0;
        end
        else if (accept)
        begin
            if (window_done)
            begin
                count_reg     <= '0;
                red_acc_reg   <= '0;
                green_acc_reg <= '0;
                blue_acc_reg  <= '0;
            end
            else
            begin
                count_reg     <= count_next;
                red_acc_reg   <= sum_next.red_sum;
                green_acc_reg <= sum_next.green_sum;
                blue_acc_reg  <= sum_next.blue_sum;
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/rwdc_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rwdc_queue
// Two-entry queue of finished window sums between front and back.
// ---------------------------------------------------------------------------
module rwdc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rwdc_pkg::window_t push_data,
    output logic              full,
    input  logic              pop,
    output rwdc_pkg::window_t pop_data,
    output logic              empty
);
    import rwdc_pkg::*;

    localparam int DEPTH = 2;

    window_t    entry_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full     = (fill_reg == 2'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/rwdc_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rwdc_back
// Scales one window's sums, runs the dominance tests through a shared
// multiplier and holds the result in the output register.
// ---------------------------------------------------------------------------
module rwdc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rwdc_pkg::cfg_t    cfg,
    input  logic              empty,
    input  rwdc_pkg::window_t pop_data,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_ready,
    output rwdc_pkg::result_t result
);
    import rwdc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP
    } state_t;

    localparam logic [2:0] STEP_RED_GAIN    = 3'd0;
    localparam logic [2:0] STEP_GREEN_GAIN  = 3'd1;
    localparam logic [2:0] STEP_BLUE_GAIN   = 3'd2;
    localparam logic [2:0] STEP_RED_RATIO   = 3'd3;
    localparam logic [2:0] STEP_GREEN_RATIO = 3'd4;
    localparam logic [2:0] STEP_BLUE_RATIO  = 3'd5;

    state_t                state_reg;
    logic [2:0]            step_reg;
    window_t               win_reg;
    logic [SCALED_W-1:0]   red_scaled_reg;
    logic [SCALED_W-1:0]   green_scaled_reg;
    logic [SCALED_W-1:0]   blue_scaled_reg;
    logic [PROD_W-1:0]     red_prod_reg;
    logic [PROD_W-1:0]     green_prod_reg;
    logic [PROD_W-1:0]     blue_prod_reg;
    logic                  result_valid_reg;
    result_t               result_reg;

    logic [SCALED_W-1:0]   mul_a;
    logic [COEF_W-1:0]     mul_b;
    logic [PROD_W-1:0]     product;
    logic [CODE_W-1:0]     code;
    logic                  out_free;
    logic                  load_result;

    // scaled a shifted up by the fraction bits against scaled b times ratio
    function automatic logic beats(
        input logic [SCALED_W-1:0] a,
        input logic [PROD_W-1:0]   b_times_ratio
    );
        begin
            return PROD_W'({a, {FRAC_W{1'b0}}}) > b_times_ratio;
        end
    endfunction

    always_comb
    begin
        unique case (step_reg)
            STEP_RED_GAIN:
            begin
                mul_a = SCALED_W'(win_reg.red_sum);
                mul_b = cfg.red_gain;
            end
            STEP_GREEN_GAIN:
            begin
                mul_a = SCALED_W'(win_reg.green_sum);
                mul_b = cfg.green_gain;
            end
            STEP_BLUE_GAIN:
            begin
                mul_a = SCALED_W'(win_reg.blue_sum);
                mul_b = cfg.blue_gain;
            end
            STEP_RED_RATIO:
            begin
                mul_a = red_scaled_reg;
                mul_b = cfg.dominance_ratio;
            end
            STEP_GREEN_RATIO:
            begin
                mul_a = green_scaled_reg;
                mul_b = cfg.dominance_ratio;
            end
            STEP_BLUE_RATIO:
            begin
                mul_a = blue_scaled_reg;
                mul_b = cfg.dominance_ratio;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        priority if (beats(red_scaled_reg, green_prod_reg)
                     && beats(red_scaled_reg, blue_prod_reg))
            code = COLOR_RED;
        else if (beats(green_scaled_reg, red_prod_reg)
                 && beats(green_scaled_reg, blue_prod_reg))
            code = COLOR_GREEN;
        else if (beats(blue_scaled_reg, red_prod_reg)
                 && beats(blue_scaled_reg, green_prod_reg))
            code = COLOR_BLUE;
        else
            code = COLOR_NONE;
    end

    assign out_free     = !result_valid_reg || result_ready;
    assign load_result  = (state_reg == ST_CMP) && out_free;
    assign pop          = (state_reg == ST_IDLE) && !empty;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_result)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!empty)
                    begin
                        win_reg   <= pop_data;
                        step_reg  <= STEP_RED_GAIN;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    unique case (step_reg)
                        STEP_RED_GAIN:    red_scaled_reg   <= product[SCALED_W-1:0];
                        STEP_GREEN_GAIN:  green_scaled_reg <= product[SCALED_W-1:0];
                        STEP_BLUE_GAIN:   blue_scaled_reg  <= product[SCALED_W-1:0];
                        STEP_RED_RATIO:   red_prod_reg     <= product;
                        STEP_GREEN_RATIO: green_prod_reg   <= product;
                        STEP_BLUE_RATIO:  blue_prod_reg    <= product;
                        default:          ;
                    endcase
                    if (step_reg == STEP_BLUE_RATIO)
                        state_reg <= ST_CMP;
                    else
                        step_reg <= step_reg + 3'd1;
                end
                ST_CMP:
                begin
                    if (out_free)
                    begin
                        result_reg.color_code       <= code;
                        result_reg.red_window_sum   <= win_reg.red_sum;
                        result_reg.green_window_sum <= win_reg.green_sum;
                        result_reg.blue_window_sum  <= win_reg.blue_sum;
                        state_reg                   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hdl/rgb_window_dominant_color_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rgb_window_dominant_color_core
// Dominant color classifier over windows of raw red, green and blue samples.
// ---------------------------------------------------------------------------
// The core takes one sample transaction per cycle unless a window-closing
// sample waits for queue room, adding each channel into a saturating 22-bit
// window sum. The sample that fills the window (length from window_length,
// zero read as one, capped at MAX_WINDOW and at 127) moves the three sums
// into a two-entry queue and clears them. The back end works through one
// window as a queue pop, six products on one shared 38x16 multiplier (three
// gain scalings, three products with dominance_ratio) and a compare step
// that loads the output register once it is free. A window-closing sample
// waits when the queue already holds two windows; other samples are always
// taken. Windows no shorter than the back end's work on a window stream at
// one sample per cycle while result_ready is high. The configuration
// port is always ready and must only be written while the core is idle.
module rgb_window_dominant_color_core #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rwdc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rwdc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  rwdc_pkg::sample_t                sample,
    output logic                             result_valid,
    input  logic                             result_ready,
    output rwdc_pkg::result_t                result
);
    import rwdc_pkg::*;

    cfg_t    cfg_reg;
    logic    push;
    window_t push_data;
    logic    queue_full;
    logic    pop;
    window_t pop_data;
    logic    queue_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length   <= WINDOW_LENGTH_RST;
            cfg_reg.red_gain        <= GAIN_RST;
            cfg_reg.green_gain      <= GAIN_RST;
            cfg_reg.blue_gain       <= GAIN_RST;
            cfg_reg.dominance_ratio <= DOMINANCE_RATIO_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH:   cfg_reg.window_length   <= cfg_data[LEN_W-1:0];
                REG_RED_GAIN:        cfg_reg.red_gain        <= cfg_data;
                REG_GREEN_GAIN:      cfg_reg.green_gain      <= cfg_data;
                REG_BLUE_GAIN:       cfg_reg.blue_gain       <= cfg_data;
                REG_DOMINANCE_RATIO: cfg_reg.dominance_ratio <= cfg_data;
                default:             ;
            endcase
        end
    end

    rwdc_front #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (cfg_reg.window_length),
        .sample_valid  (sample_valid),
        .sample_ready  (sample_ready),
        .sample        (sample),
        .queue_full    (queue_full),
        .push          (push),
        .push_data     (push_data)
    );

    rwdc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    rwdc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .empty        (queue_empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire
